### sv/dlr_pkg.sv
// DDA line rasterizer: shared types and codes.
// Used by dlr_ctrl, dlr_dpath and dda_line_rasterizer_core. No dependencies.
`timescale 1ns / 1ps

package dlr_pkg;

  // op field of an input transaction
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_line;  // start transaction accepted
    logic advance;    // advance transaction accepted on an active line
    logic div_step;   // one iteration of the increment dividers
    logic emit;       // load the output register from the position
  } dlr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_zero; // endpoints on the input port are equal
    logic div_last;   // current divider iteration is the final one
    logic line_last;  // pixel now in the position register ends the line
  } dlr_status_t;

endpackage

### sv/dlr_div.sv
// Radix-2 restoring divider for one axis increment, one quotient bit a cycle.
// Forms round(mag * 2^FRAC_BITS / divisor); quotient ready after FRAC_BITS+1 steps.
// No package dependency.
`timescale 1ns / 1ps

module dlr_div #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned FRAC_BITS  = 20
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic                  step_i,
  input  logic [COORD_BITS-1:0] mag_i,
  input  logic [COORD_BITS-1:0] divisor_i,
  output logic [FRAC_BITS:0]    quot_o
);

  localparam int unsigned NumW = COORD_BITS + FRAC_BITS + 1;

  logic [COORD_BITS-1:0] div_q;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [FRAC_BITS:0]    lo_q, lo_d;   // low dividend bits, quotient shifts in behind
  logic [NumW-1:0]       num;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  ge;

  // dividend with the rounding term: (mag << F) + divisor / 2
  assign num = {1'b0, mag_i, {FRAC_BITS{1'b0}}}
             + {{(FRAC_BITS + 2){1'b0}}, divisor_i[COORD_BITS-1:1]};

  assign trial = {rem_q, lo_q[FRAC_BITS]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    rem_d = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
    lo_d  = {lo_q[FRAC_BITS-1:0], ge};
  end

  // quotient is at most 2^F, so the top COORD_BITS dividend bits are below the divisor
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      div_q <= divisor_i;
      rem_q <= num[NumW-1:FRAC_BITS+1];
      lo_q  <= num[FRAC_BITS:0];
    end else if (step_i) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
    end
  end

  assign quot_o = lo_q;

endmodule

### sv/dlr_dpath.sv
// DDA line rasterizer datapath: delta/step setup, increment dividers, position
// accumulators, step counter and output register. Uses dlr_pkg and dlr_div.
`timescale 1ns / 1ps

module dlr_dpath #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned FRAC_BITS  = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dlr_pkg::dlr_cmd_t            cmd_i,
  output dlr_pkg::dlr_status_t         status_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         last_pixel_o
);

  localparam int unsigned PosW = COORD_BITS + FRAC_BITS;
  localparam int unsigned IncW = FRAC_BITS + 2;
  localparam int unsigned CntW = $clog2(FRAC_BITS + 2);
  localparam logic [CntW-1:0] CntLast = CntW'(FRAC_BITS);
  localparam logic [CntW-1:0] CntDone = CntW'(FRAC_BITS + 1);
  localparam logic [COORD_BITS-1:0] StepOne = COORD_BITS'(1);

  logic [PosW-1:0]       pos_x_q, pos_y_q;
  logic [IncW-1:0]       inc_x_q, inc_y_q;
  logic [COORD_BITS-1:0] steps_left_q;
  logic                  last_q;
  logic                  neg_x_q, neg_y_q;
  logic [CntW-1:0]       cnt_q;
  logic [COORD_BITS-1:0] pix_x_q, pix_y_q;
  logic                  pix_last_q;

  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0] mag_x, mag_y, steps;
  logic [FRAC_BITS:0]    quot_x, quot_y;
  logic                  div_last;

  function automatic logic [COORD_BITS-1:0] to_pixel(input logic [PosW-1:0] p);
    logic [PosW-1:0]       mag;
    logic [COORD_BITS-1:0] t;
    mag = p[PosW-1] ? (~p + PosW'(1)) : p;
    t   = mag[PosW-1:FRAC_BITS];
    return p[PosW-1] ? (~t + COORD_BITS'(1)) : t;
  endfunction

  function automatic logic [IncW-1:0] signed_inc(input logic neg,
                                                 input logic [FRAC_BITS:0] q);
    logic [IncW-1:0] qe;
    qe = {1'b0, q};
    return neg ? (~qe + IncW'(1)) : qe;
  endfunction

  function automatic logic [PosW-1:0] sext_inc(input logic [IncW-1:0] inc);
    return {{(PosW - IncW){inc[IncW-1]}}, inc};
  endfunction

  assign dx    = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign dy    = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
  assign mag_x = dx[COORD_BITS] ? COORD_BITS'(~dx + 1'b1) : dx[COORD_BITS-1:0];
  assign mag_y = dy[COORD_BITS] ? COORD_BITS'(~dy + 1'b1) : dy[COORD_BITS-1:0];
  assign steps = (mag_x > mag_y) ? mag_x : mag_y;

  assign div_last = (cnt_q == CntLast);

  dlr_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_x (
    .clk_i    (clk_i),
    .load_i   (cmd_i.load_line),
    .step_i   (cmd_i.div_step),
    .mag_i    (mag_x),
    .divisor_i(steps),
    .quot_o   (quot_x)
  );

  dlr_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_y (
    .clk_i    (clk_i),
    .load_i   (cmd_i.load_line),
    .step_i   (cmd_i.div_step),
    .mag_i    (mag_y),
    .divisor_i(steps),
    .quot_o   (quot_y)
  );

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      inc_x_q      <= '0;
      inc_y_q      <= '0;
      steps_left_q <= '0;
      last_q       <= 1'b0;
      neg_x_q      <= 1'b0;
      neg_y_q      <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (cmd_i.load_line) begin
        pos_x_q      <= {start_x_i, {FRAC_BITS{1'b0}}};
        pos_y_q      <= {start_y_i, {FRAC_BITS{1'b0}}};
        steps_left_q <= steps;
        last_q       <= (steps == '0);
        neg_x_q      <= dx[COORD_BITS];
        neg_y_q      <= dy[COORD_BITS];
        cnt_q        <= '0;
      end else if (cmd_i.advance) begin
        pos_x_q      <= pos_x_q + sext_inc(inc_x_q);
        pos_y_q      <= pos_y_q + sext_inc(inc_y_q);
        steps_left_q <= steps_left_q - StepOne;
        last_q       <= (steps_left_q == StepOne);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      // dividers finish their quotient at the last div_step edge; capture it at the next emit
      if (cmd_i.emit && !last_q && (cnt_q == CntDone)) begin
        inc_x_q <= signed_inc(neg_x_q, quot_x);
        inc_y_q <= signed_inc(neg_y_q, quot_y);
        cnt_q   <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pix_x_q    <= to_pixel(pos_x_q);
      pix_y_q    <= to_pixel(pos_y_q);
      pix_last_q <= last_q;
    end
  end

  assign status_o.start_zero = (steps == '0);
  assign status_o.div_last   = div_last;
  assign status_o.line_last  = last_q;

  assign pixel_x_o    = pix_x_q;
  assign pixel_y_o    = pix_y_q;
  assign last_pixel_o = pix_last_q;

endmodule

### sv/dlr_ctrl.sv
// DDA line rasterizer controller: input/output handshakes and line sequencing.
// Drives dlr_pkg::dlr_cmd_t to the datapath, reads dlr_pkg::dlr_status_t.
`timescale 1ns / 1ps

module dlr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dlr_pkg::dlr_cmd_t    cmd_o,
  input  dlr_pkg::dlr_status_t status_i
);

  localparam logic [1:0] S_IDLE   = 2'd0;  // no line
  localparam logic [1:0] S_ACTIVE = 2'd1;  // line open, waiting for advance
  localparam logic [1:0] S_DIV    = 2'd2;  // computing increments
  localparam logic [1:0] S_EMIT   = 2'd3;  // pixel waits for the output register

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_stall_o = !((state_q == S_IDLE) || (state_q == S_ACTIVE));
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.load_line = accept && (op_i == dlr_pkg::OP_START);
    cmd_o.advance   = accept && (op_i == dlr_pkg::OP_ADVANCE) && (state_q == S_ACTIVE);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.emit      = (state_q == S_EMIT) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE, S_ACTIVE: begin
        if (cmd_o.load_line) begin
          state_d = status_i.start_zero ? S_EMIT : S_DIV;
        end else if (cmd_o.advance) begin
          state_d = S_EMIT;
        end
      end
      S_DIV: begin
        if (status_i.div_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cmd_o.emit) begin
          state_d = status_i.line_last ? S_IDLE : S_ACTIVE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/dda_line_rasterizer_core.sv
// DDA line rasterizer, top level. Start transaction: the bit-serial increment
// dividers run, then the pixel goes to the output register (a zero-length line skips
// the dividers). Advance: add the increments to the position, then convert it into
// the output register. No new transaction is taken until the pixel is registered.
// Reset (async, active low) leaves no line open and no pixel pending.
`timescale 1ns / 1ps

module dda_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned FRAC_BITS  = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         last_pixel_o
);

  dlr_pkg::dlr_cmd_t    cmd;
  dlr_pkg::dlr_status_t status;

  dlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  dlr_dpath #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_pixel_o(last_pixel_o)
  );

endmodule

### bench/dda_line_rasterizer_core_tb.sv
// Testbench for dda_line_rasterizer_core: directed and random line transactions,
// a pixel predictor and scoreboard, random idling on both channels.
// Depends on dlr_pkg and dda_line_rasterizer_core.
`timescale 1ns / 1ps

module dda_line_rasterizer_core_tb;

  localparam int unsigned COORD_BITS = 11;
  localparam int unsigned FRAC_BITS  = 20;
  localparam int unsigned POS_BITS   = COORD_BITS + FRAC_BITS;
  localparam int          RAND_ITEMS = 200;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          COORD_MIN  = -(1 << (COORD_BITS - 1));
  localparam int          COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [POS_BITS-1:0]   pos_t;
  typedef logic signed [FRAC_BITS+1:0]  inc_t;

  localparam coord_t CMIN = coord_t'(COORD_MIN);
  localparam coord_t CMAX = coord_t'(COORD_MAX);

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  class pixel_scoreboard;
    pos_t            pos_x, pos_y;
    inc_t            inc_x, inc_y;
    logic [COORD_BITS:0] steps_left;
    bit              line_open;
    pixel_t          pixel_q[$];
    int              mismatches;

    function new();
      pos_x = '0;
      pos_y = '0;
      inc_x = '0;
      inc_y = '0;
      steps_left = '0;
      line_open = 1'b0;
      mismatches = 0;
    endfunction

    task report_mismatch(string field, logic signed [31:0] got, logic signed [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $time);
      mismatches++;
    endtask

    // truncate toward zero, then wrap to the coordinate width
    function coord_t pixel_of(pos_t p);
      longint v, t;
      v = p;
      t = (v < 0 ? -v : v) >> FRAC_BITS;
      if (v < 0) t = -t;
      return coord_t'(t);
    endfunction

    // |d| / steps rounded half away from zero, sign of d
    function inc_t step_of(longint d, longint steps);
      longint q;
      q = (((d < 0 ? -d : d) << FRAC_BITS) + steps / 2) / steps;
      return inc_t'(d < 0 ? -q : q);
    endfunction

    // returns 1 when the transaction produces a pixel
    function bit note_input(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      longint dx, dy, ax, ay, steps;
      pixel_t px;
      if (op == dlr_pkg::OP_START) begin
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        steps = ax > ay ? ax : ay;
        pos_x = pos_t'(longint'(sx) <<< FRAC_BITS);
        pos_y = pos_t'(longint'(sy) <<< FRAC_BITS);
        if (steps == 0) begin
          inc_x = '0;
          inc_y = '0;
          steps_left = '0;
          line_open = 1'b0;
        end else begin
          inc_x = step_of(dx, steps);
          inc_y = step_of(dy, steps);
          steps_left = (COORD_BITS + 1)'(steps);
          line_open = 1'b1;
        end
      end else begin
        if (!line_open) return 1'b0;
        pos_x = pos_x + inc_x;
        pos_y = pos_y + inc_y;
        steps_left = steps_left - 1'b1;
        if (steps_left == 0) line_open = 1'b0;
      end
      px.x = pixel_of(pos_x);
      px.y = pixel_of(pos_y);
      px.last = !line_open;
      pixel_q.push_back(px);
      return 1'b1;
    endfunction

    task check_result(coord_t x, coord_t y, logic last);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        report_mismatch("pixel_x with no pixel pending", x, 0);
        return;
      end
      want = pixel_q.pop_front();
      if (x !== want.x) report_mismatch("pixel_x", x, want.x);
      if (y !== want.y) report_mismatch("pixel_y", y, want.y);
      if (last !== want.last) report_mismatch("last_pixel", {31'b0, last}, {31'b0, want.last});
    endtask

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   op_i = dlr_pkg::OP_START;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic   out_stall_i = 1'b0;
  logic   in_stall_o;
  logic   out_valid_o;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;

  pixel_scoreboard sb = new();
  bit     no_idle = 1'b0;
  int     pixel_items = 0;
  int     cycles = 0;

  dda_line_rasterizer_core #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_pixel_o(last_pixel_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  task automatic send_item(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (sb.note_input(op, sx, sy, ex, ey)) pixel_items++;
  endtask

  // start transaction followed by a number of advances with junk coordinates
  task automatic run_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, int advances);
    send_item(dlr_pkg::OP_START, sx, sy, ex, ey);
    repeat (advances)
      send_item(dlr_pkg::OP_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom));
  endtask

  // output stall: random stretches, none while no_idle is set
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_result(pixel_x_o, pixel_y_o, last_pixel_o);
  end

  initial begin
    coord_t sx, sy, ex, ey;
    int     span, r, n, adv;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_item(dlr_pkg::OP_ADVANCE, '1, '1, '1, '1);        // advance while idle
    run_line('0, '0, '0, '0, 0);                            // zero-length line
    run_line(CMIN, CMAX, CMIN, CMAX, 0);
    run_line(CMAX, CMIN, CMAX, CMIN, 0);
    run_line('0, '0, coord_t'(5), coord_t'(2), 5);          // shallow, full length
    send_item(dlr_pkg::OP_ADVANCE, '0, '0, '0, '0);        // after the last pixel
    run_line(coord_t'(3), coord_t'(-2), coord_t'(-1), coord_t'(-7), 5); // negative steep
    run_line(CMIN, CMIN, CMAX, CMAX, 2);                    // dropped by next start
    run_line(CMAX, CMAX, CMIN, CMIN, 2);
    run_line(CMIN, CMAX, CMAX, CMIN, 1);

    // random line sequences plus noise
    pixel_items = 0;
    while (pixel_items < RAND_ITEMS) begin
      no_idle = (pixel_items >= 60 && pixel_items < 90) ||
                (pixel_items >= 150 && pixel_items < 165);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item(logic'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom));
      end else begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        r = $urandom_range(0, 99);
        span = r < 70 ? 12 : 100;
        if (r >= 90) begin
          ex = coord_t'($urandom);
          ey = coord_t'($urandom);
        end else if (r < 5) begin
          ex = sx;
          ey = sy;
        end else begin
          ex = clamp_coord(int'(sx) + int'($urandom_range(0, 2 * span)) - span);
          ey = clamp_coord(int'(sy) + int'($urandom_range(0, 2 * span)) - span);
        end
        n = int'(ex) - int'(sx);
        if (n < 0) n = -n;
        adv = int'(ey) - int'(sy);
        if (adv < 0) adv = -adv;
        if (adv > n) n = adv;
        adv = n > 40 ? $urandom_range(0, 40) : n;
        r = $urandom_range(0, 99);
        if (r < 15) adv = $urandom_range(0, adv);
        else if (r < 25) adv += $urandom_range(1, 3);
        run_line(sx, sy, ex, ey, adv);
      end
    end
    no_idle = 1'b0;

    // one long line run to its end, plus one advance past it
    run_line(coord_t'(-300), coord_t'(211), coord_t'(-141), coord_t'(95), 160);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (FRAC_BITS + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### dda_line_rasterizer_core.f
sv/dlr_pkg.sv
sv/dlr_div.sv
sv/dlr_dpath.sv
sv/dlr_ctrl.sv
sv/dda_line_rasterizer_core.sv
bench/dda_line_rasterizer_core_tb.sv
